// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define SLR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// same-cycle implication
`define SLR_IMPLY(lbl, clk_s, rst_s, pre, post, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) else $error(msg);

`endif

// File: hw/rtl/slrsp_pkg.sv
`default_nettype none

package slrsp_pkg;

	localparam int NUM_STATES  = 21;
	localparam int NUM_TOKENS  = 9;
	localparam int NUM_NONTERM = 6;
	localparam int NUM_PRODS   = 11;
	localparam int MAX_RESULTS = 64;

	localparam int TOK_W   = 4;
	localparam int STATE_W = 5;
	localparam int PROD_W  = 4;
	localparam int LEN_W   = 3;
	localparam int LHS_W   = 3;
	localparam int CNT_W   = 6;

	typedef enum logic [1:0] {
		ACT_SHIFT  = 2'd0,
		ACT_REDUCE = 2'd1,
		ACT_ACCEPT = 2'd2,
		ACT_ERROR  = 2'd3
	} act_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NO_ACTION = 2'd1,
		ERR_NO_GOTO   = 2'd2,
		ERR_FULL      = 2'd3
	} err_code_t;

	// action table entry: kind in [7:6], argument in [5:0]
	typedef enum logic [1:0] {
		TK_NONE   = 2'd0,
		TK_SHIFT  = 2'd1,
		TK_REDUCE = 2'd2,
		TK_ACCEPT = 2'd3
	} tab_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_REDUCE
	} ctl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHIFT,
		OP_READ,
		OP_REDUCE,
		OP_ACCEPT,
		OP_FAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t    op;
		err_code_t err;
	} dp_cmd_t;

	typedef struct packed {
		logic      finished;
		tab_kind_t tk;
		logic      shift_full;
		logic      red_short;
		logic      goto_zero;
		logic      red_full;
		logic      out_free;
	} dp_sts_t;

	function automatic logic [7:0] sh(input logic [STATE_W-1:0] s);
		return {TK_SHIFT, 1'b0, s};
	endfunction

	function automatic logic [7:0] rd(input logic [PROD_W-1:0] p);
		return {TK_REDUCE, 2'b00, p};
	endfunction

	localparam logic [7:0] AN  = {TK_NONE, 6'd0};
	localparam logic [7:0] ACC = {TK_ACCEPT, 6'd0};

	// columns: id num lparen rparen plus times assign semicolon end
	localparam logic [7:0] ACT_TAB [NUM_STATES][NUM_TOKENS] = '{
		'{sh(5'd7), AN, AN, AN, AN, AN, AN, AN, rd(4'd2)},
		'{AN, AN, AN, AN, AN, AN, AN, AN, ACC},
		'{AN, AN, AN, AN, AN, AN, AN, AN, rd(4'd0)},
		'{sh(5'd7), AN, AN, AN, AN, AN, AN, AN, rd(4'd2)},
		'{sh(5'd7), AN, AN, AN, AN, AN, AN, AN, rd(4'd2)},
		'{rd(4'd1), AN, AN, AN, AN, AN, AN, AN, rd(4'd1)},
		'{sh(5'd15), sh(5'd16), sh(5'd13), AN, AN, AN, AN, AN, AN},
		'{AN, AN, AN, AN, AN, AN, sh(5'd6), AN, AN},
		'{AN, AN, AN, AN, sh(5'd18), AN, AN, sh(5'd17), AN},
		'{AN, AN, AN, rd(4'd5), rd(4'd5), sh(5'd19), AN, rd(4'd5), AN},
		'{AN, AN, AN, rd(4'd7), rd(4'd7), rd(4'd7), AN, rd(4'd7), AN},
		'{AN, AN, AN, rd(4'd4), rd(4'd4), sh(5'd19), AN, rd(4'd4), AN},
		'{AN, AN, AN, rd(4'd6), rd(4'd6), rd(4'd6), AN, rd(4'd6), AN},
		'{sh(5'd15), sh(5'd16), sh(5'd13), AN, AN, AN, AN, AN, AN},
		'{AN, AN, AN, sh(5'd20), sh(5'd18), AN, AN, AN, AN},
		'{AN, AN, AN, rd(4'd8), rd(4'd8), rd(4'd8), AN, rd(4'd8), AN},
		'{AN, AN, AN, rd(4'd9), rd(4'd9), rd(4'd9), AN, rd(4'd9), AN},
		'{rd(4'd3), AN, AN, AN, AN, AN, AN, AN, rd(4'd3)},
		'{sh(5'd15), sh(5'd16), sh(5'd13), AN, AN, AN, AN, AN, AN},
		'{sh(5'd15), sh(5'd16), sh(5'd13), AN, AN, AN, AN, AN, AN},
		'{AN, AN, AN, rd(4'd10), rd(4'd10), rd(4'd10), AN, rd(4'd10), AN}
	};

	// columns: program, statement list, statement, expression, term, factor
	localparam logic [STATE_W-1:0] GOTO_TAB [NUM_STATES][NUM_NONTERM] = '{
		'{5'd1, 5'd2, 5'd3, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd8, 5'd9, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd11, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd14, 5'd9, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd11, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
	};

	localparam logic [LHS_W-1:0] PROD_LHS [NUM_PRODS] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
	};

	localparam logic [LEN_W-1:0] PROD_LEN [NUM_PRODS] = '{
		3'd1, 3'd2, 3'd0, 3'd4, 3'd3, 3'd1, 3'd3, 3'd1, 3'd1, 3'd1, 3'd3
	};

endpackage

`default_nettype wire

// File: hw/rtl/slrsp_ctrl.sv
`default_nettype none

module slrsp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire slrsp_pkg::dp_sts_t sts,
	output slrsp_pkg::dp_cmd_t      cmd
);

	slrsp_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slrsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = slrsp_pkg::OP_NONE;
		cmd.err  = slrsp_pkg::ERR_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			slrsp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = slrsp_pkg::OP_LOAD;
					state_d = slrsp_pkg::ST_DECIDE;
				end
			end
			slrsp_pkg::ST_DECIDE: begin
				if (sts.finished) begin
					if (sts.out_free) begin
						cmd.op  = slrsp_pkg::OP_FAIL;
						cmd.err = slrsp_pkg::ERR_FULL;
						state_d = slrsp_pkg::ST_IDLE;
					end
				end else begin
					unique case (sts.tk)
						slrsp_pkg::TK_NONE: begin
							if (sts.out_free) begin
								cmd.op  = slrsp_pkg::OP_FAIL;
								cmd.err = slrsp_pkg::ERR_NO_ACTION;
								state_d = slrsp_pkg::ST_IDLE;
							end
						end
						slrsp_pkg::TK_ACCEPT: begin
							if (sts.out_free) begin
								cmd.op  = slrsp_pkg::OP_ACCEPT;
								state_d = slrsp_pkg::ST_IDLE;
							end
						end
						slrsp_pkg::TK_SHIFT: begin
							if (sts.out_free) begin
								if (sts.shift_full) begin
									cmd.op  = slrsp_pkg::OP_FAIL;
									cmd.err = slrsp_pkg::ERR_FULL;
								end else begin
									cmd.op = slrsp_pkg::OP_SHIFT;
								end
								state_d = slrsp_pkg::ST_IDLE;
							end
						end
						slrsp_pkg::TK_REDUCE: begin
							if (sts.red_short) begin
								if (sts.out_free) begin
									cmd.op  = slrsp_pkg::OP_FAIL;
									cmd.err = slrsp_pkg::ERR_NO_GOTO;
									state_d = slrsp_pkg::ST_IDLE;
								end
							end else begin
								cmd.op  = slrsp_pkg::OP_READ;
								state_d = slrsp_pkg::ST_REDUCE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			slrsp_pkg::ST_REDUCE: begin
				if (sts.out_free) begin
					if (sts.goto_zero) begin
						cmd.op  = slrsp_pkg::OP_FAIL;
						cmd.err = slrsp_pkg::ERR_NO_GOTO;
						state_d = slrsp_pkg::ST_IDLE;
					end else if (sts.red_full) begin
						cmd.op  = slrsp_pkg::OP_FAIL;
						cmd.err = slrsp_pkg::ERR_FULL;
						state_d = slrsp_pkg::ST_IDLE;
					end else begin
						cmd.op  = slrsp_pkg::OP_REDUCE;
						state_d = slrsp_pkg::ST_DECIDE;
					end
				end
			end
			default: begin
				state_d = slrsp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/slrsp_dp.sv
`default_nettype none

`include "assert_macros.svh"

module slrsp_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [slrsp_pkg::TOK_W-1:0]   token_kind,
	input  wire logic                          start_new,
	input  wire slrsp_pkg::dp_cmd_t            cmd,
	output slrsp_pkg::dp_sts_t                 sts,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         act_kind,
	output logic [slrsp_pkg::PROD_W-1:0]       production,
	output logic [slrsp_pkg::STATE_W-1:0]      next_state,
	output logic [1:0]                         error_code,
	output logic                               last
);

	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [SP_W:0]   DEPTH_X = (SP_W + 1)'(STACK_DEPTH);
	localparam logic [SP_W-1:0] DEPTH_S = SP_W'(STACK_DEPTH);

	logic [slrsp_pkg::TOK_W-1:0]   tok_q;
	logic [slrsp_pkg::STATE_W-1:0] top_q;
	logic [SP_W-1:0]               sp_q;
	logic                          fin_q;
	logic [slrsp_pkg::CNT_W-1:0]   cnt_q;
	logic [slrsp_pkg::PROD_W-1:0]  prod_q;
	logic [slrsp_pkg::LEN_W-1:0]   len_q;
	logic                          base_zero_q;
	logic [slrsp_pkg::STATE_W-1:0] rd_data_q;
	logic [slrsp_pkg::STATE_W-1:0] stack_mem [STACK_DEPTH];

	logic                          out_valid_q;
	slrsp_pkg::act_kind_t          act_kind_q;
	logic [slrsp_pkg::PROD_W-1:0]  prod_out_q;
	logic [slrsp_pkg::STATE_W-1:0] st_out_q;
	slrsp_pkg::err_code_t          err_out_q;
	logic                          last_q;

	logic [7:0]                    code;
	logic [5:0]                    arg;
	logic [slrsp_pkg::PROD_W-1:0]  act_prod;
	logic [slrsp_pkg::LEN_W-1:0]   act_len;
	logic [SP_W-1:0]               rd_addr_full;
	logic [ADDR_W-1:0]             rd_addr;
	logic [slrsp_pkg::STATE_W-1:0] base;
	logic [slrsp_pkg::LHS_W-1:0]   lhs;
	logic [slrsp_pkg::STATE_W-1:0] goto_st;
	logic [SP_W:0]                 nsp;
	logic [SP_W-1:0]               red_wr_full;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_wa;
	logic [slrsp_pkg::STATE_W-1:0] mem_wd;
	logic                          emit;
	slrsp_pkg::act_kind_t          emit_kind;
	logic [slrsp_pkg::PROD_W-1:0]  emit_prod;
	logic [slrsp_pkg::STATE_W-1:0] emit_st;
	slrsp_pkg::err_code_t          emit_err;
	logic                          emit_last;
	logic                          end_held;

	// action lookup on the current top of stack
	always_comb begin
		if (top_q < slrsp_pkg::STATE_W'(slrsp_pkg::NUM_STATES) &&
				tok_q < slrsp_pkg::TOK_W'(slrsp_pkg::NUM_TOKENS)) begin
			code = slrsp_pkg::ACT_TAB[top_q][tok_q];
		end else begin
			code = slrsp_pkg::AN;
		end
	end

	assign arg          = code[5:0];
	assign act_prod     = arg[slrsp_pkg::PROD_W-1:0];
	assign act_len      = (act_prod < slrsp_pkg::PROD_W'(slrsp_pkg::NUM_PRODS)) ?
		slrsp_pkg::PROD_LEN[act_prod] : '0;
	assign rd_addr_full = sp_q - SP_W'(1) - SP_W'(act_len);
	assign rd_addr      = rd_addr_full[ADDR_W-1:0];

	// goto lookup on the registered base state
	assign base = base_zero_q ? '0 : rd_data_q;
	assign lhs  = slrsp_pkg::PROD_LHS[prod_q];

	always_comb begin
		if (base < slrsp_pkg::STATE_W'(slrsp_pkg::NUM_STATES)) begin
			goto_st = slrsp_pkg::GOTO_TAB[base][lhs];
		end else begin
			goto_st = '0;
		end
	end

	assign nsp         = {1'b0, sp_q} - (SP_W + 1)'(len_q) + (SP_W + 1)'(1);
	assign red_wr_full = sp_q - SP_W'(len_q);

	assign sts.finished   = fin_q;
	assign sts.tk         = slrsp_pkg::tab_kind_t'(code[7:6]);
	assign sts.shift_full = sp_q >= DEPTH_S;
	assign sts.red_short  = sp_q <= SP_W'(act_len);
	assign sts.goto_zero  = goto_st == '0;
	assign sts.red_full   = (nsp > DEPTH_X) ||
		(cnt_q >= slrsp_pkg::CNT_W'(slrsp_pkg::MAX_RESULTS - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = sp_q[ADDR_W-1:0];
		mem_wd = arg[slrsp_pkg::STATE_W-1:0];
		unique case (cmd.op)
			slrsp_pkg::OP_SHIFT: begin
				mem_we = 1'b1;
			end
			slrsp_pkg::OP_REDUCE: begin
				mem_we = 1'b1;
				mem_wa = red_wr_full[ADDR_W-1:0];
				mem_wd = goto_st;
			end
			default: begin
			end
		endcase
	end

	// entry zero is never written, its state 0 comes from base_zero_q
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (cmd.op == slrsp_pkg::OP_READ) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == slrsp_pkg::OP_LOAD) begin
			tok_q <= token_kind;
		end
		if (cmd.op == slrsp_pkg::OP_READ) begin
			prod_q      <= act_prod;
			len_q       <= act_len;
			base_zero_q <= rd_addr == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			sp_q  <= SP_W'(1);
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				slrsp_pkg::OP_LOAD: begin
					cnt_q <= '0;
					if (start_new) begin
						top_q <= '0;
						sp_q  <= SP_W'(1);
						fin_q <= 1'b0;
					end
				end
				slrsp_pkg::OP_SHIFT: begin
					sp_q  <= sp_q + SP_W'(1);
					top_q <= arg[slrsp_pkg::STATE_W-1:0];
				end
				slrsp_pkg::OP_REDUCE: begin
					sp_q  <= nsp[SP_W-1:0];
					top_q <= goto_st;
					cnt_q <= cnt_q + slrsp_pkg::CNT_W'(1);
				end
				slrsp_pkg::OP_ACCEPT, slrsp_pkg::OP_FAIL: begin
					fin_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		emit      = 1'b1;
		emit_kind = slrsp_pkg::ACT_ERROR;
		emit_prod = '0;
		emit_st   = top_q;
		emit_err  = slrsp_pkg::ERR_NONE;
		emit_last = 1'b1;
		unique case (cmd.op)
			slrsp_pkg::OP_SHIFT: begin
				emit_kind = slrsp_pkg::ACT_SHIFT;
				emit_st   = arg[slrsp_pkg::STATE_W-1:0];
			end
			slrsp_pkg::OP_REDUCE: begin
				emit_kind = slrsp_pkg::ACT_REDUCE;
				emit_prod = prod_q;
				emit_st   = goto_st;
				emit_last = 1'b0;
			end
			slrsp_pkg::OP_ACCEPT: begin
				emit_kind = slrsp_pkg::ACT_ACCEPT;
			end
			slrsp_pkg::OP_FAIL: begin
				emit_err = cmd.err;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			act_kind_q <= emit_kind;
			prod_out_q <= emit_prod;
			st_out_q   <= emit_st;
			err_out_q  <= emit_err;
			last_q     <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign act_kind   = act_kind_q;
	assign production = prod_out_q;
	assign next_state = st_out_q;
	assign error_code = err_out_q;
	assign last       = last_q;

	assign end_held = out_valid_q &&
		(act_kind_q == slrsp_pkg::ACT_ERROR || act_kind_q == slrsp_pkg::ACT_ACCEPT);

	`SLR_ASSERT(a_sp_range, clk, arst_n, (sp_q != '0) && (sp_q <= DEPTH_S), "sp out of range")
	`SLR_IMPLY(a_emit_free, clk, arst_n, emit, sts.out_free, "result over held transaction")
	`SLR_IMPLY(a_end_last, clk, arst_n, end_held, last_q, "accept or error without last")

endmodule

`default_nettype wire

// File: hw/rtl/slr_statement_parser_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    token_kind, start_new
// out      output     out_valid / out_stall  act_kind, production, next_state, error_code, last
//
// tokens load in idle and are decided in decide; a reduction steps through decide and reduce
// each reduction waits on the registered read of the state stack memory before the goto lookup
// reset leaves state 0 alone on the stack and the parser not finished; no clearing pass
// results leave through an output register; a held result stalls the controller, not the stack
// in_stall is high from acceptance until the final result of the token is registered

`default_nettype none

module slr_statement_parser_unit #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [slrsp_pkg::TOK_W-1:0]   token_kind,
	input  wire logic                          start_new,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         act_kind,
	output logic [slrsp_pkg::PROD_W-1:0]       production,
	output logic [slrsp_pkg::STATE_W-1:0]      next_state,
	output logic [1:0]                         error_code,
	output logic                               last
);

	slrsp_pkg::dp_cmd_t cmd;
	slrsp_pkg::dp_sts_t sts;

	slrsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	slrsp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.token_kind (token_kind),
		.start_new  (start_new),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.act_kind   (act_kind),
		.production (production),
		.next_state (next_state),
		.error_code (error_code),
		.last       (last)
	);

endmodule

`default_nettype wire

// File: tb/tb_slr_statement_parser_unit.sv
module tb_slr_statement_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 32;
	localparam int PHASE_ITEMS = 146;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;

	localparam logic [3:0] T_IDENT = 4'd0;
	localparam logic [3:0] T_NUMBER = 4'd1;
	localparam logic [3:0] T_LPAREN = 4'd2;
	localparam logic [3:0] T_RPAREN = 4'd3;
	localparam logic [3:0] T_PLUS = 4'd4;
	localparam logic [3:0] T_TIMES = 4'd5;
	localparam logic [3:0] T_ASSIGN = 4'd6;
	localparam logic [3:0] T_SEMI = 4'd7;
	localparam logic [3:0] T_END = 4'd8;
	localparam logic [3:0] T_UNKNOWN_LO = 4'd9;
	localparam logic [3:0] T_UNKNOWN_HI = 4'd15;

	localparam int NT_PROGRAM = 0;
	localparam int NT_STMT_LIST = 1;
	localparam int NT_STMT = 2;
	localparam int NT_EXPR = 3;
	localparam int NT_TERM = 4;
	localparam int NT_FACTOR = 5;

	typedef enum logic [1:0] {
		EK_BLANK,
		EK_SHIFT,
		EK_REDUCE,
		EK_ACCEPT
	} entry_kind_t;

	typedef struct packed {
		slrsp_pkg::act_kind_t kind;
		logic [3:0]           prod;
		logic [4:0]           state;
		slrsp_pkg::err_code_t err;
		logic                 last;
	} parse_action_t;

	typedef struct packed {
		logic [3:0]           tok;
		logic                 sn;
		logic                 typed;
		slrsp_pkg::act_kind_t kind;
		logic [4:0]           state;
		slrsp_pkg::err_code_t err;
	} token_row_t;

	function automatic logic [7:0] shf(input logic [4:0] s);
		return {EK_SHIFT, 1'b0, s};
	endfunction

	function automatic logic [7:0] red(input logic [3:0] p);
		return {EK_REDUCE, 2'b00, p};
	endfunction

	localparam logic [7:0] BL = {EK_BLANK, 6'd0};
	localparam logic [7:0] AC = {EK_ACCEPT, 6'd0};

	// columns: ident number lparen rparen plus times assign semicolon end
	localparam logic [7:0] SHIFT_REDUCE_TAB [slrsp_pkg::NUM_STATES][slrsp_pkg::NUM_TOKENS] = '{
		'{shf(5'd7), BL, BL, BL, BL, BL, BL, BL, red(4'd2)},
		'{BL, BL, BL, BL, BL, BL, BL, BL, AC},
		'{BL, BL, BL, BL, BL, BL, BL, BL, red(4'd0)},
		'{shf(5'd7), BL, BL, BL, BL, BL, BL, BL, red(4'd2)},
		'{shf(5'd7), BL, BL, BL, BL, BL, BL, BL, red(4'd2)},
		'{red(4'd1), BL, BL, BL, BL, BL, BL, BL, red(4'd1)},
		'{shf(5'd15), shf(5'd16), shf(5'd13), BL, BL, BL, BL, BL, BL},
		'{BL, BL, BL, BL, BL, BL, shf(5'd6), BL, BL},
		'{BL, BL, BL, BL, shf(5'd18), BL, BL, shf(5'd17), BL},
		'{BL, BL, BL, red(4'd5), red(4'd5), shf(5'd19), BL, red(4'd5), BL},
		'{BL, BL, BL, red(4'd7), red(4'd7), red(4'd7), BL, red(4'd7), BL},
		'{BL, BL, BL, red(4'd4), red(4'd4), shf(5'd19), BL, red(4'd4), BL},
		'{BL, BL, BL, red(4'd6), red(4'd6), red(4'd6), BL, red(4'd6), BL},
		'{shf(5'd15), shf(5'd16), shf(5'd13), BL, BL, BL, BL, BL, BL},
		'{BL, BL, BL, shf(5'd20), shf(5'd18), BL, BL, BL, BL},
		'{BL, BL, BL, red(4'd8), red(4'd8), red(4'd8), BL, red(4'd8), BL},
		'{BL, BL, BL, red(4'd9), red(4'd9), red(4'd9), BL, red(4'd9), BL},
		'{red(4'd3), BL, BL, BL, BL, BL, BL, BL, red(4'd3)},
		'{shf(5'd15), shf(5'd16), shf(5'd13), BL, BL, BL, BL, BL, BL},
		'{shf(5'd15), shf(5'd16), shf(5'd13), BL, BL, BL, BL, BL, BL},
		'{BL, BL, BL, red(4'd10), red(4'd10), red(4'd10), BL, red(4'd10), BL}
	};

	// zero means no goto
	localparam logic [4:0] GOTO_STATE_TAB [slrsp_pkg::NUM_STATES][slrsp_pkg::NUM_NONTERM] = '{
		'{5'd1, 5'd2, 5'd3, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd8, 5'd9, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd11, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd14, 5'd9, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd11, 5'd10},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
	};

	localparam int RULE_LHS [slrsp_pkg::NUM_PRODS] = '{
		NT_PROGRAM, NT_STMT_LIST, NT_STMT_LIST, NT_STMT, NT_EXPR, NT_EXPR,
		NT_TERM, NT_TERM, NT_FACTOR, NT_FACTOR, NT_FACTOR
	};
	localparam int RULE_LEN [slrsp_pkg::NUM_PRODS] = '{1, 2, 0, 4, 3, 1, 3, 1, 1, 1, 3};

	localparam token_row_t DIRECTED [22] = '{
		'{T_UNKNOWN_LO, 1'b0, 1'b1, slrsp_pkg::ACT_ERROR, 5'd0, slrsp_pkg::ERR_NO_ACTION},
		'{T_IDENT, 1'b0, 1'b1, slrsp_pkg::ACT_ERROR, 5'd0, slrsp_pkg::ERR_FULL},
		'{T_IDENT, 1'b1, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd7, slrsp_pkg::ERR_NONE},
		'{T_ASSIGN, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd6, slrsp_pkg::ERR_NONE},
		'{T_NUMBER, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd16, slrsp_pkg::ERR_NONE},
		'{T_TIMES, 1'b0, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_LPAREN, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd13, slrsp_pkg::ERR_NONE},
		'{T_IDENT, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd15, slrsp_pkg::ERR_NONE},
		'{T_PLUS, 1'b0, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_NUMBER, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd16, slrsp_pkg::ERR_NONE},
		'{T_RPAREN, 1'b0, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_SEMI, 1'b0, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_END, 1'b0, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_UNKNOWN_HI, 1'b1, 1'b1, slrsp_pkg::ACT_ERROR, 5'd0, slrsp_pkg::ERR_NO_ACTION},
		'{T_END, 1'b1, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE},
		'{T_RPAREN, 1'b1, 1'b1, slrsp_pkg::ACT_ERROR, 5'd0, slrsp_pkg::ERR_NO_ACTION},
		'{T_SEMI, 1'b0, 1'b1, slrsp_pkg::ACT_ERROR, 5'd0, slrsp_pkg::ERR_FULL},
		'{T_IDENT, 1'b1, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd7, slrsp_pkg::ERR_NONE},
		'{T_ASSIGN, 1'b0, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd6, slrsp_pkg::ERR_NONE},
		'{T_ASSIGN, 1'b0, 1'b1, slrsp_pkg::ACT_ERROR, 5'd6, slrsp_pkg::ERR_NO_ACTION},
		'{T_IDENT, 1'b1, 1'b1, slrsp_pkg::ACT_SHIFT, 5'd7, slrsp_pkg::ERR_NONE},
		'{T_END, 1'b0, 1'b1, slrsp_pkg::ACT_ERROR, 5'd7, slrsp_pkg::ERR_NO_ACTION}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [slrsp_pkg::TOK_W-1:0] token_kind = T_IDENT;
	logic start_new = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] act_kind;
	logic [slrsp_pkg::PROD_W-1:0] production;
	logic [slrsp_pkg::STATE_W-1:0] next_state;
	logic [1:0] error_code;
	logic last;

	logic [4:0] parser_stack [STACK_DEPTH];
	int unsigned stack_used;
	bit parse_done;
	parse_action_t step_actions [$];
	parse_action_t expected_actions [$];
	token_row_t token_q [$];
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches = 0;
	int stuck_cycles = 0;

	slr_statement_parser_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void note_action(input slrsp_pkg::act_kind_t k, input logic [3:0] p,
			input logic [4:0] s, input slrsp_pkg::err_code_t e);
		parse_action_t a;
		a = '{k, p, s, e, 1'b0};
		step_actions.insert(step_actions.size(), a);
	endfunction

	function automatic void clear_parser_stack();
		foreach (parser_stack[i]) parser_stack[i] = 5'd0;
		stack_used = 1;
	endfunction

	function automatic void parse_token(input logic [3:0] tok, input logic sn);
		logic [4:0] top;
		logic [4:0] base;
		logic [4:0] goal;
		logic [7:0] code;
		int unsigned rule;
		int unsigned len;
		bit busy;
		step_actions.delete();
		if (sn) begin
			clear_parser_stack();
			parse_done = 1'b0;
		end
		busy = !parse_done;
		if (parse_done)
			note_action(slrsp_pkg::ACT_ERROR, 4'd0, parser_stack[stack_used-1],
				slrsp_pkg::ERR_FULL);
		while (busy) begin
			top = parser_stack[stack_used-1];
			code = (top < slrsp_pkg::NUM_STATES && tok < slrsp_pkg::NUM_TOKENS) ?
				SHIFT_REDUCE_TAB[top][tok] : BL;
			busy = 1'b0;
			case (entry_kind_t'(code[7:6]))
				EK_BLANK: note_action(slrsp_pkg::ACT_ERROR, 4'd0, top, slrsp_pkg::ERR_NO_ACTION);
				EK_ACCEPT: note_action(slrsp_pkg::ACT_ACCEPT, 4'd0, top, slrsp_pkg::ERR_NONE);
				EK_SHIFT: begin
					if (stack_used >= STACK_DEPTH) begin
						note_action(slrsp_pkg::ACT_ERROR, 4'd0, top, slrsp_pkg::ERR_FULL);
					end else begin
						parser_stack[stack_used] = code[4:0];
						stack_used++;
						note_action(slrsp_pkg::ACT_SHIFT, 4'd0, code[4:0], slrsp_pkg::ERR_NONE);
					end
				end
				EK_REDUCE: begin
					rule = 32'(code[3:0]);
					len = RULE_LEN[rule];
					if (stack_used <= len) begin
						note_action(slrsp_pkg::ACT_ERROR, 4'd0, top, slrsp_pkg::ERR_NO_GOTO);
					end else begin
						base = parser_stack[stack_used-1-len];
						goal = (base < slrsp_pkg::NUM_STATES) ?
							GOTO_STATE_TAB[base][RULE_LHS[rule]] : 5'd0;
						if (goal == 5'd0) begin
							note_action(slrsp_pkg::ACT_ERROR, 4'd0, top, slrsp_pkg::ERR_NO_GOTO);
						end else if (stack_used - len + 1 > STACK_DEPTH ||
								step_actions.size() >= slrsp_pkg::MAX_RESULTS - 1) begin
							note_action(slrsp_pkg::ACT_ERROR, 4'd0, top, slrsp_pkg::ERR_FULL);
						end else begin
							parser_stack[stack_used-len] = goal;
							stack_used = stack_used - len + 1;
							note_action(slrsp_pkg::ACT_REDUCE, rule[3:0], goal,
								slrsp_pkg::ERR_NONE);
							busy = 1'b1;
						end
					end
				end
			endcase
		end
		if (step_actions[$].kind != slrsp_pkg::ACT_SHIFT)
			parse_done = 1'b1;
		step_actions[$].last = 1'b1;
	endfunction

	function automatic void add_tok(input logic [3:0] t, input logic sn);
		token_row_t row;
		row = '{t, sn, 1'b0, slrsp_pkg::ACT_SHIFT, 5'd0, slrsp_pkg::ERR_NONE};
		token_q.insert(token_q.size(), row);
	endfunction

	task automatic gen_expr(input int depth);
		int terms;
		int factors;
		terms = $urandom_range(1, 3);
		for (int t = 0; t < terms; t++) begin
			if (t > 0)
				add_tok(T_PLUS, 1'b0);
			factors = $urandom_range(1, 2);
			for (int f = 0; f < factors; f++) begin
				if (f > 0)
					add_tok(T_TIMES, 1'b0);
				if (depth > 0 && $urandom_range(3) == 0) begin
					add_tok(T_LPAREN, 1'b0);
					gen_expr(depth - 1);
					add_tok(T_RPAREN, 1'b0);
				end else begin
					add_tok($urandom_range(1) ? T_IDENT : T_NUMBER, 1'b0);
				end
			end
		end
	endtask

	task automatic gen_program(input int stmts, input int depth);
		for (int i = 0; i < stmts; i++) begin
			add_tok(T_IDENT, 1'b0);
			add_tok(T_ASSIGN, 1'b0);
			gen_expr(depth);
			add_tok(T_SEMI, 1'b0);
		end
		add_tok(T_END, 1'b0);
		token_q[0].sn = 1'b1;
	endtask

	task automatic build_chunk();
		int pick;
		int idx;
		int nest;
		token_q.delete();
		pick = $urandom_range(99);
		if (pick < 55) begin
			gen_program($urandom_range(0, 4), 2);
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 2)) add_tok(4'($urandom_range(15)), 1'b0);
		end else if (pick < 70) begin
			// broken statement: corrupt or drop one token, or cut the stream after it and end there
			gen_program($urandom_range(1, 3), 2);
			idx = $urandom_range(token_q.size() - 1);
			case ($urandom_range(2))
				0: token_q[idx].tok = 4'($urandom_range(15));
				1: token_q.delete(idx);
				default: begin
					while (token_q.size() > idx + 1) void'(token_q.pop_back());
					add_tok(T_END, 1'b0);
				end
			endcase
			if (token_q.size() > 0)
				token_q[0].sn = 1'b1;
		end else if (pick < 80) begin
			// deep nesting that can run the state stack out of room
			nest = $urandom_range(24, 31);
			add_tok(T_IDENT, 1'b1);
			add_tok(T_ASSIGN, 1'b0);
			repeat (nest) add_tok(T_LPAREN, 1'b0);
			add_tok(T_IDENT, 1'b0);
			repeat (nest) add_tok(T_RPAREN, 1'b0);
			add_tok(T_SEMI, 1'b0);
			add_tok(T_END, 1'b0);
		end else if (pick < 85) begin
			gen_program($urandom_range(20, 31), 0);
		end else begin
			repeat ($urandom_range(1, 6))
				add_tok(4'($urandom_range(15)), 1'($urandom_range(1)));
		end
	endtask

	task automatic send_token(input token_row_t row);
		parse_action_t typed_act;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		token_kind <= row.tok;
		start_new <= row.sn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_token(row.tok, row.sn);
		if (row.typed) begin
			typed_act = '{row.kind, 4'd0, row.state, row.err, 1'b1};
			expected_actions.insert(expected_actions.size(), typed_act);
		end else begin
			foreach (step_actions[i])
				expected_actions.insert(expected_actions.size(), step_actions[i]);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		parse_action_t want;
		parse_action_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = parse_action_t'({act_kind, production, next_state, error_code, last});
			if (expected_actions.size() == 0) begin
				mismatches++;
				$display("%0t expected no result", $time);
				$display("%0t actual   kind %0d prod %0d state %0d err %0d last %0d",
					$time, got.kind, got.prod, got.state, got.err, got.last);
			end else begin
				want = expected_actions.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t expected kind %0d prod %0d state %0d err %0d last %0d",
						$time, want.kind, want.prod, want.state, want.err, want.last);
					$display("%0t actual   kind %0d prod %0d state %0d err %0d last %0d",
						$time, got.kind, got.prod, got.state, got.err, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("slr_statement_parser_unit: mismatch");
		$finish;
	end

	initial begin
		int sent;
		clear_parser_stack();
		parse_done = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 75;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) send_token(DIRECTED[i]);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_chunk();
				while (token_q.size() != 0 && sent < PHASE_ITEMS) begin
					send_token(token_q.pop_front());
					sent++;
				end
			end
			// sender holds off until every outstanding transaction has drained
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_actions.size() == 0)
			$display("slr_statement_parser_unit: match");
		else
			$display("slr_statement_parser_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/slrsp_pkg.sv
hw/rtl/slrsp_ctrl.sv
hw/rtl/slrsp_dp.sv
hw/rtl/slr_statement_parser_unit.sv
tb/tb_slr_statement_parser_unit.sv
